// ----- sv/lrc_pkg.sv -----
// Package for the LRU result cache: request codes and key width.
// No dependencies.
package lrc_pkg;
	localparam int KEY_W = 64;
	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_RSVD   = 2'd3;
endpackage

// ----- sv/lru_result_cache.sv -----
// Fully associative LRU result cache, one entry memory swept per request.
// Depends on lrc_pkg.
//
// Usage: drive req_type, key_high, key_low, payload and pulse start while
// busy is low; the item is taken at that edge. The block answers every item
// with one result, shown for one cycle with done high: hit, payload_out,
// evicted and occupancy. The receiver cannot stall; done is never held.
// Lookups and adds sweep the entry memory (one synchronous RAM, one read
// and one write a cycle): a scan pass finds the key, victim and free slot,
// then an update pass rewrites the recency ranks. A lookup miss answers
// after the scan pass alone, with no update pass; clear and unused codes
// answer on the next cycle. busy is low while done is high, so the next
// start may be taken in the done cycle.
// cfg_we writes the capacity register; write it only while idle. Reset
// clears the valid bits and count and sets capacity to 64; RAM contents are
// not cleared, valid bits gate every read.
module lru_result_cache #(
	parameter int CAPACITY      = 64,
	parameter int PAYLOAD_WIDTH = 32,
	localparam int CW           = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    req_type,
	input  logic [63:0]   key_high,
	input  logic [63:0]   key_low,
	input  logic [31:0]   payload,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata,
	output logic          done,
	output logic          hit,
	output logic [31:0]   payload_out,
	output logic          evicted,
	output logic [CW-1:0] occupancy
);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KW = lrc_pkg::KEY_W;
	localparam int WW = 2 * KW + PAYLOAD_WIDTH + IW;
	localparam int EW = (CW > 7) ? CW : 7;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [WW-1:0] mem [CAPACITY];
	logic [WW-1:0] rdata_s1;
	logic [IW-1:0] idx_s1;
	logic          rvld_s1;
	logic          we;
	logic [WW-1:0] wdata;

	logic [1:0]    state_q;
	logic [IW:0]   ctr_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CW-1:0] cnt_q;
	logic [6:0]    cap_q;
	logic [1:0]    req_q;
	logic [KW-1:0] khi_q, klo_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic          ev_q, found_q, slotf_q;
	logic [IW-1:0] midx_q, vidx_q, slot_q;
	logic [IW-1:0] mrank_q;
	logic [PAYLOAD_WIDTH-1:0] mdata_q;

	logic [KW-1:0] r_khi, r_klo;
	logic [PAYLOAD_WIDTH-1:0] r_dat;
	logic [IW-1:0] r_rank;
	logic          r_v, r_vict, r_match, r_free, issue, scan_end, ev_now;
	logic [IW-1:0] n_rank;
	logic [CAPACITY-1:0] nxt_valid;
	logic [CW-1:0] nxt_cnt;

	assign busy = (state_q != ST_IDLE);
	assign {r_khi, r_klo, r_dat, r_rank} = rdata_s1;
	assign issue = busy && (ctr_q != (IW + 1)'(CAPACITY));
	assign scan_end = busy && !issue && !rvld_s1;
	assign r_v = valid_q[idx_s1];
	assign r_vict = ev_q && r_v && (CW'(r_rank) == cnt_q - CW'(1));
	assign r_match = r_v && !r_vict && (r_khi == khi_q) && (r_klo == klo_q);
	assign r_free = !r_v || r_vict;
	assign ev_now = (cnt_q != '0) && ((cap_q == '0) || (EW'(cnt_q) >= EW'(cap_q))
		|| (cnt_q == CW'(CAPACITY)));

	always_comb begin
		n_rank = r_rank;
		wdata = rdata_s1;
		if (found_q) begin
			if (idx_s1 == midx_q) begin
				n_rank = '0;
			end else if (r_v && !r_vict && r_rank < mrank_q) begin
				n_rank = r_rank + IW'(1);
			end
			wdata = {r_khi, r_klo, r_dat, n_rank};
		end else if (idx_s1 == slot_q) begin
			wdata = {khi_q, klo_q, pay_q, {IW{1'b0}}};
		end else begin
			if (r_v && !r_vict) begin
				n_rank = r_rank + IW'(1);
			end
			wdata = {r_khi, r_klo, r_dat, n_rank};
		end
	end
	assign we = (state_q == ST_UPD) && rvld_s1;

	always_comb begin
		nxt_valid = valid_q;
		nxt_cnt = cnt_q;
		if (ev_q) begin
			nxt_valid[vidx_q] = 1'b0;
			nxt_cnt = nxt_cnt - CW'(1);
		end
		if (!found_q && slotf_q) begin
			nxt_valid[slot_q] = 1'b1;
			nxt_cnt = nxt_cnt + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[ctr_q[IW-1:0]];
		end
		if (we) begin
			mem[idx_s1] <= wdata;
		end
		idx_s1 <= ctr_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctr_q <= '0;
			rvld_s1 <= 1'b0;
			valid_q <= '0;
			cnt_q <= '0;
			cap_q <= 7'd64;
			done <= 1'b0;
			hit <= 1'b0;
			payload_out <= '0;
			evicted <= 1'b0;
			occupancy <= '0;
			found_q <= 1'b0;
			slotf_q <= 1'b0;
			ev_q <= 1'b0;
		end else begin
			done <= 1'b0;
			rvld_s1 <= issue;
			if (issue) begin
				ctr_q <= ctr_q + (IW + 1)'(1);
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req_type;
						khi_q <= key_high;
						klo_q <= key_low;
						pay_q <= payload[PAYLOAD_WIDTH-1:0];
						ev_q <= (req_type == lrc_pkg::REQ_ADD) && ev_now;
						found_q <= 1'b0;
						slotf_q <= 1'b0;
						ctr_q <= '0;
						if (req_type == lrc_pkg::REQ_LOOKUP || req_type == lrc_pkg::REQ_ADD) begin
							state_q <= ST_SCAN;
						end else begin
							done <= 1'b1;
							hit <= 1'b0;
							payload_out <= '0;
							evicted <= 1'b0;
							if (req_type == lrc_pkg::REQ_CLEAR) begin
								valid_q <= '0;
								cnt_q <= '0;
								occupancy <= '0;
							end else begin
								occupancy <= cnt_q;
							end
						end
					end
				end
				ST_SCAN: begin
					if (rvld_s1) begin
						if (r_match && !found_q) begin
							found_q <= 1'b1;
							midx_q <= idx_s1;
							mrank_q <= r_rank;
							mdata_q <= r_dat;
						end
						if (r_free && !slotf_q) begin
							slotf_q <= 1'b1;
							slot_q <= idx_s1;
						end
						if (r_vict) begin
							vidx_q <= idx_s1;
						end
					end
					if (scan_end) begin
						ctr_q <= '0;
						if (req_q == lrc_pkg::REQ_ADD || found_q) begin
							state_q <= ST_UPD;
						end else begin
							state_q <= ST_IDLE;
							done <= 1'b1;
							hit <= 1'b0;
							payload_out <= '0;
							evicted <= 1'b0;
							occupancy <= cnt_q;
						end
					end
				end
				ST_UPD: begin
					if (scan_end) begin
						state_q <= ST_IDLE;
						done <= 1'b1;
						hit <= found_q;
						evicted <= ev_q;
						payload_out <= (req_q == lrc_pkg::REQ_LOOKUP && found_q)
							? 32'(mdata_q) : '0;
						valid_q <= nxt_valid;
						cnt_q <= nxt_cnt;
						occupancy <= nxt_cnt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY)) else $error("entry count above capacity");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == lrc_pkg::REQ_CLEAR) |=> (done && occupancy == '0))
		else $error("clear did not empty the cache");
	a_cnt_ones: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ($countones(valid_q) == int'(cnt_q)))
		else $error("valid bits disagree with count");
endmodule
